FILE: src/lhp_pkg.sv
// Shared types and constants for the length header parser.
// Holds the parse phase encoding, character codes and the result record.
// No dependencies.
package lhp_pkg;

  // Parse phases of the header scanner.
  typedef enum logic [2:0] {
    PH_KEY0 = 3'd0,  // expect the first digit of a key, or '#'
    PH_KEY  = 3'd1,  // inside the key digits
    PH_VAL0 = 3'd2,  // expect the first digit of a value
    PH_VAL  = 3'd3,  // inside the value digits
    PH_BODY = 3'd4   // header done, counting body bytes
  } phase_e;

  // Characters of the header syntax.
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

  // Result kinds.
  localparam logic KIND_PAIR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Width of the length fields on the result stream.
  localparam int unsigned OUT_LEN_W = 24;

  // Result queue geometry.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // One result item as it waits in the queue.
  typedef struct packed {
    logic                 kind;
    logic [OUT_LEN_W-1:0] key_length;
    logic [OUT_LEN_W-1:0] value_length;
    logic                 format_ok;
    logic                 run_end;
  } result_t;

  // What one parsed byte hands to the result queue.
  typedef struct packed {
    logic                 pair_valid;
    logic                 verdict_valid;
    logic [OUT_LEN_W-1:0] key_length;
    logic [OUT_LEN_W-1:0] value_length;
    logic                 format_ok;
  } push_t;

endpackage

FILE: src/lhp_parser.sv
// Header scanner of the length header parser: phase, accumulators and counters.
// Decides per byte which results to emit. Depends on lhp_pkg.
module lhp_parser
  import lhp_pkg::*;
#(
  parameter int unsigned LEN_BITS   = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output push_t      push_o
);

  localparam int unsigned MAC_W = LEN_BITS + 4;
  localparam int unsigned SUM_W = ((LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS) + 1;

  phase_e                phase_q, phase_d;
  logic [LEN_BITS-1:0]   key_q, key_d;
  logic [LEN_BITS-1:0]   value_q, value_d;
  logic [COUNT_BITS-1:0] needed_q, needed_d;
  logic [COUNT_BITS-1:0] body_q, body_d;
  logic                  err_q, err_d;

  logic                          is_digit;
  logic [3:0]                    digit;
  logic [LEN_BITS-1:0]           acc_src;
  logic [MAC_W-1:0]              acc_ext;
  logic [MAC_W-1:0]              mac;
  logic                          mac_ovf;
  logic [SUM_W-1:0]              sum;
  logic                          sum_ovf;
  logic [COUNT_BITS-1:0]         needed_add;
  logic [COUNT_BITS-1:0]         body_inc;
  logic                          ok_cmp;
  logic [LEN_BITS+OUT_LEN_W-1:0] key_ext;
  logic [LEN_BITS+OUT_LEN_W-1:0] value_ext;

  always_comb begin
    is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    digit    = byte_i[3:0];

    // One shared times-ten accumulate and one shared length adder.
    acc_src = (phase_q == PH_KEY) ? key_q : value_q;
    acc_ext = MAC_W'(acc_src);
    mac     = (acc_ext << 3) + (acc_ext << 1) + MAC_W'(digit);
    mac_ovf = |mac[MAC_W-1:LEN_BITS];

    sum        = SUM_W'(needed_q) + SUM_W'(acc_src);
    sum_ovf    = |sum[SUM_W-1:COUNT_BITS];
    needed_add = sum_ovf ? '1 : sum[COUNT_BITS-1:0];

    body_inc = (&body_q) ? body_q : body_q + 1'b1;

    phase_d  = phase_q;
    key_d    = key_q;
    value_d  = value_q;
    needed_d = needed_q;
    body_d   = body_q;
    err_d    = err_q;
    push_o   = '0;

    if (!err_q) begin
      case (phase_q)
        PH_KEY0: begin
          if (is_digit) begin
            key_d   = LEN_BITS'(digit);
            phase_d = PH_KEY;
          end else if (byte_i == CH_HASH) begin
            phase_d = PH_BODY;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_KEY: begin
          if (is_digit) begin
            if (mac_ovf) err_d = 1'b1;
            else         key_d = mac[LEN_BITS-1:0];
          end else if (byte_i == CH_DASH) begin
            needed_d = needed_add;
            err_d    = sum_ovf;
            phase_d  = PH_VAL0;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_VAL0: begin
          if (is_digit) begin
            value_d = LEN_BITS'(digit);
            phase_d = PH_VAL;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_VAL: begin
          if (is_digit) begin
            if (mac_ovf) err_d   = 1'b1;
            else         value_d = mac[LEN_BITS-1:0];
          end else begin
            // The value's digit run ends here: the pair goes out even if the
            // running sum overflows.
            push_o.pair_valid = 1'b1;
            needed_d          = needed_add;
            err_d             = sum_ovf;
            if (byte_i == CH_COMMA)     phase_d = PH_KEY0;
            else if (byte_i == CH_HASH) phase_d = PH_BODY;
            else                        err_d   = 1'b1;
          end
        end
        PH_BODY: begin
          body_d = body_inc;
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    // The pair reports the value as it stands after this byte, including a
    // first value digit that arrives on the last byte of the stream.
    key_ext   = (LEN_BITS + OUT_LEN_W)'(key_q);
    value_ext = (LEN_BITS + OUT_LEN_W)'(value_d);

    // Body length check. Body bytes are counted only in the body phase, so on
    // entering it the count is zero and the check reduces to a zero total.
    // A zero sum of two lengths means both were zero, so no adder sits here.
    case (phase_q)
      PH_BODY: ok_cmp = (body_inc >= needed_q);
      PH_VAL:  ok_cmp = (needed_q == '0) && (value_q == '0);
      default: ok_cmp = (needed_q == '0);
    endcase

    if (last_i) begin
      if (!err_d && (phase_d == PH_VAL)) push_o.pair_valid = 1'b1;
      push_o.verdict_valid = 1'b1;
      push_o.format_ok     = !err_d && (phase_d == PH_BODY) && ok_cmp;
      // The stream is over: back to the start for the next one.
      phase_d  = PH_KEY0;
      key_d    = '0;
      value_d  = '0;
      needed_d = '0;
      body_d   = '0;
      err_d    = 1'b0;
    end

    push_o.key_length   = key_ext[OUT_LEN_W-1:0];
    push_o.value_length = value_ext[OUT_LEN_W-1:0];

    if (!step_i) begin
      push_o.pair_valid    = 1'b0;
      push_o.verdict_valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KEY0;
      key_q    <= '0;
      value_q  <= '0;
      needed_q <= '0;
      body_q   <= '0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      key_q    <= key_d;
      value_q  <= value_d;
      needed_q <= needed_d;
      body_q   <= body_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: src/lhp_outq.sv
// Result queue of the length header parser: four entries, up to two writes
// per cycle, one read per cycle. Depends on lhp_pkg.
module lhp_outq
  import lhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    room_o
);

  result_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d;
  logic [Q_PTR_W-1:0]   rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]           n_push;
  logic [Q_PTR_W-1:0]   wr_next;
  result_t              pair_res;
  result_t              verdict_res;
  result_t              first_res;

  always_comb begin
    pair_res.kind         = KIND_PAIR;
    pair_res.key_length   = push_i.key_length;
    pair_res.value_length = push_i.value_length;
    pair_res.format_ok    = 1'b0;
    pair_res.run_end      = !push_i.verdict_valid;

    verdict_res.kind         = KIND_VERDICT;
    verdict_res.key_length   = '0;
    verdict_res.value_length = '0;
    verdict_res.format_ok    = push_i.format_ok;
    verdict_res.run_end      = 1'b1;

    first_res = push_i.pair_valid ? pair_res : verdict_res;
    n_push    = {1'b0, push_i.pair_valid} + {1'b0, push_i.verdict_valid};
    wr_next   = wr_q + 1'b1;

    wr_d  = wr_q + n_push[Q_PTR_W-1:0];
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(n_push) - Q_CNT_W'(pop_i);
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != '0);
  // Room for the two results a byte can cause, without looking at the pop.
  assign room_o  = (cnt_q <= Q_CNT_W'(Q_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= first_res;
    if (n_push == 2'd2) mem_q[wr_next] <= verdict_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/length_header_parser.sv
// Top level of the length header parser: input register, header scanner and
// result queue. Depends on lhp_pkg, lhp_parser and lhp_outq.
//
//  Channel  Direction  Signals                          Transaction
//  -------  ---------  -------------------------------  ---------------------------
//  s_axis   in         tvalid tready tdata[7:0] tlast   one stream byte
//  m_axis   out        tvalid tready tdata[55:0] tlast  one length pair or verdict
//                      tuser
//
// A byte is taken into the input register and scanned while it sits there,
// as soon as the queue has room; its results enter the queue at the end of the
// cycle in which it is scanned and are offered from the queue. The scanner
// handles one byte per cycle while the queue has room; the output drains one
// result per cycle while tready is high, and a byte that ends a value on the
// last byte of the stream causes two results. The scanner moves on while the
// four-entry result queue holds at most two results, and the input register
// takes a new byte whenever it is empty or its byte is scanned, which keeps
// bytes flowing while results wait.
// Reset (rst_ni low) returns the scanner to the start of a stream and empties
// the queue; after each verdict the scanner also restarts on its own.
module length_header_parser
  import lhp_pkg::*;
#(
  parameter int unsigned LEN_BITS   = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [23:0] key_length, [47:24] value_length,
                                        // [48] format_ok, [55:49] zero
  output logic        m_axis_tlast_o,   // run_end: last result of its byte
  output logic        m_axis_tuser_o    // kind: 0 length pair, 1 verdict
);

  // Input register: one byte waiting for the scanner.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic    s_fire;
  logic    step;
  logic    room;
  logic    pop;
  push_t   push;
  result_t head;

  // The scanner advances when a byte is held and the queue can take both
  // results that the byte might cause.
  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire)    in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  lhp_parser #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .push_o (push)
  );

  assign pop = m_axis_tvalid_o && m_axis_tready_i;

  lhp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .room_o  (room)
  );

  assign m_axis_tdata_o = {7'b0, head.format_ok, head.value_length, head.key_length};
  assign m_axis_tlast_o = head.run_end;
  assign m_axis_tuser_o = head.kind;

  // A verdict always closes the results of its byte.
  a_verdict_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_VERDICT) |-> m_axis_tlast_o)
    else $error("verdict result without run end");

  // A pair that is not the last result of its byte is followed by the verdict.
  a_pair_then_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (m_axis_tuser_o == KIND_PAIR) && !m_axis_tlast_o
    |=> m_axis_tvalid_o && (m_axis_tuser_o == KIND_VERDICT))
    else $error("pair without run end not followed by its verdict");

  // Length pairs never carry a verdict bit.
  a_pair_no_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_PAIR) |-> !m_axis_tdata_o[48])
    else $error("length pair with format_ok set");

  // A held byte that the scanner did not take stays in the input register.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input register lost a byte");

endmodule
